// ----- rtl/core/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg
// Types and constants of the heading and speed extrapolator pipeline.
// ----------------------------------------------------------------------------
package hse_pkg;

  // pipeline depth, one register per stage
  localparam int unsigned NUM_STG = 9;

  // reset value of the step time register, 0.1 s in 0.16 format
  localparam logic [15:0] STEP_TIME_RST = 16'd6554;

  // sine polynomial coefficients, Q14
  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [14:0] SIN_B = 15'd10512;
  localparam logic [14:0] SIN_C = 15'd1160;

  // binary angle of a quarter turn
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // half an lsb of the 2^-31 scaled displacement
  localparam logic [47:0] ROUND_HALF = 48'h0000_4000_0000;

  // one trig lane: sine drives x, cosine drives y
  typedef struct packed {
    logic               neg;
    logic [14:0]        mag;
    logic [14:0]        z2;
    logic [14:0]        t;
    logic [14:0]        trig;
    logic [30:0]        prod;
    logic [46:0]        scaled;
    logic signed [17:0] disp;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] speed;
    logic               sum_neg;
    logic [16:0]        sum_mag;
    logic               sat;
    lane_t [1:0]        ln;
  } stage_t;

endpackage

// ----- rtl/core/hse_in_if.sv -----
// ----------------------------------------------------------------------------
// hse_in_if
// Input channel: current and previous state sample of one agent.
// ----------------------------------------------------------------------------
interface hse_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [15:0] cur_heading;
  logic signed [15:0] cur_speed;
  logic signed [15:0] prev_heading;
  logic signed [15:0] prev_speed;

  modport source (
    output valid, cur_x, cur_y, cur_heading, cur_speed, prev_heading, prev_speed,
    input  ready
  );
  modport sink (
    input  valid, cur_x, cur_y, cur_heading, cur_speed, prev_heading, prev_speed,
    output ready
  );
endinterface

// ----- rtl/core/hse_out_if.sv -----
// ----------------------------------------------------------------------------
// hse_out_if
// Output channel: one extrapolated state estimate.
// ----------------------------------------------------------------------------
interface hse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic signed [15:0] est_heading;
  logic signed [15:0] est_speed;
  logic               saturated;

  modport source (
    output valid, est_x, est_y, est_heading, est_speed, saturated,
    input  ready
  );
  modport sink (
    input  valid, est_x, est_y, est_heading, est_speed, saturated,
    output ready
  );
endinterface

// ----- rtl/core/hse_cfg_if.sv -----
// ----------------------------------------------------------------------------
// hse_cfg_if
// Configuration write channel for the step time register.
// ----------------------------------------------------------------------------
interface hse_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] step_time;

  modport source (
    output valid, step_time,
    input  ready
  );
  modport sink (
    input  valid, step_time,
    output ready
  );
endinterface

// ----- rtl/core/heading_speed_extrapolator_core.sv -----
// ----------------------------------------------------------------------------
// heading_speed_extrapolator_core
// Dead reckoning over one time step with constant turn rate and acceleration.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one agent sample (position, heading and speed now and one
//   step earlier); out_o returns one estimate per word, in order.
//   cfg_i writes the step time (unsigned 0.16 seconds); it is always ready
//   and should only be written while no word is in flight.
// Throughput: one word per cycle while out_o is ready. The nine stages
//   are: decode and angle fold, square, two polynomial stages,
//   sine/cosine product, speed product, step time product, rounding,
//   position add with saturation.
// Reset: all stage valid bits clear, step time returns to 0.1 s.
// Stall: a stage holds its word while the next one is full and not moving;
//   empty stages further up still fill, so in_i.ready only drops once all
//   nine stages hold a word and out_o is stalled. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module heading_speed_extrapolator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hse_in_if.sink     in_i,
  hse_out_if.source  out_o,
  hse_cfg_if.sink    cfg_i
);
  import hse_pkg::*;

  logic [15:0]          step_q;
  logic [NUM_STG-1:0]   vld_q;
  logic [NUM_STG-1:0]   vld_d;
  logic [NUM_STG-1:0]   adv;
  stage_t               stg_q [NUM_STG];
  stage_t               stg_d [NUM_STG];

  // step time register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_TIME_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      step_q <= cfg_i.step_time;
    end
  end

  // a stage moves when it is empty or its successor moves
  always_comb begin
    adv[NUM_STG-1] = !vld_q[NUM_STG-1] || out_o.ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_i.ready = adv[0];
  assign vld_d      = {vld_q[NUM_STG-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~adv) | (vld_d & adv);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STG; k++) begin
      if (adv[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // stage logic
  always_comb begin
    logic [15:0]        ang;
    logic signed [16:0] fold_s;
    logic signed [17:0] spd_raw;
    logic signed [16:0] spd_sum;
    logic [29:0]        sq;
    logic [25:0]        c1;
    logic [29:0]        c2;
    logic [29:0]        c3;
    logic [31:0]        p;
    logic [47:0]        rnd;
    logic [16:0]        r;
    logic signed [32:0] pos_sum;

    // decode: heading, speed and angle folding
    stg_d[0]         = '0;
    stg_d[0].pos_x   = in_i.cur_x;
    stg_d[0].pos_y   = in_i.cur_y;
    stg_d[0].heading = {in_i.cur_heading[14:0], 1'b0} - in_i.prev_heading;
    spd_raw = {in_i.cur_speed[15], in_i.cur_speed, 1'b0}
            - {{2{in_i.prev_speed[15]}}, in_i.prev_speed};
    if (spd_raw[17:15] != 3'b000 && spd_raw[17:15] != 3'b111) begin
      stg_d[0].speed = spd_raw[17] ? 16'sh8000 : 16'sh7FFF;
      stg_d[0].sat   = 1'b1;
    end else begin
      stg_d[0].speed = spd_raw[15:0];
    end
    spd_sum = {in_i.cur_speed[15], in_i.cur_speed} + {stg_d[0].speed[15], stg_d[0].speed};
    stg_d[0].sum_neg = spd_sum[16];
    stg_d[0].sum_mag = spd_sum[16] ? 17'(-spd_sum) : 17'(spd_sum);
    for (int l = 0; l < 2; l++) begin
      // cosine is sine a quarter turn on
      ang    = (l == 0) ? in_i.cur_heading : in_i.cur_heading + QUARTER_TURN;
      fold_s = {ang[15], ang};
      if (fold_s > 17'sd16384) begin
        fold_s = 17'sd32768 - fold_s;
      end else if (fold_s < -17'sd16384) begin
        fold_s = -17'sd32768 - fold_s;
      end
      stg_d[0].ln[l].neg = fold_s[16];
      stg_d[0].ln[l].mag = fold_s[16] ? 15'(-fold_s) : 15'(fold_s);
    end

    // square of the folded angle
    stg_d[1] = stg_q[0];
    for (int l = 0; l < 2; l++) begin
      sq = 30'(stg_q[0].ln[l].mag) * 30'(stg_q[0].ln[l].mag);
      stg_d[1].ln[l].z2 = sq[28:14];
    end

    // inner polynomial term
    stg_d[2] = stg_q[1];
    for (int l = 0; l < 2; l++) begin
      c1 = 26'(SIN_C) * 26'(stg_q[1].ln[l].z2);
      stg_d[2].ln[l].t = SIN_B - {3'b000, c1[25:14]};
    end

    // outer polynomial term
    stg_d[3] = stg_q[2];
    for (int l = 0; l < 2; l++) begin
      c2 = 30'(stg_q[2].ln[l].t) * 30'(stg_q[2].ln[l].z2);
      stg_d[3].ln[l].t = SIN_A - c2[28:14];
    end

    // trig magnitude, Q14
    stg_d[4] = stg_q[3];
    for (int l = 0; l < 2; l++) begin
      c3 = 30'(stg_q[3].ln[l].mag) * 30'(stg_q[3].ln[l].t);
      stg_d[4].ln[l].trig = c3[28:14];
    end

    // speed sum times trig, sign kept apart
    stg_d[5] = stg_q[4];
    for (int l = 0; l < 2; l++) begin
      p = 32'(stg_q[4].sum_mag) * 32'(stg_q[4].ln[l].trig);
      stg_d[5].ln[l].prod = p[30:0];
      stg_d[5].ln[l].neg  = stg_q[4].ln[l].neg ^ stg_q[4].sum_neg;
    end

    // scale by step time
    stg_d[6] = stg_q[5];
    for (int l = 0; l < 2; l++) begin
      stg_d[6].ln[l].scaled = 47'(stg_q[5].ln[l].prod) * 47'(step_q);
    end

    // round half away from zero to 24.8 metres
    stg_d[7] = stg_q[6];
    for (int l = 0; l < 2; l++) begin
      rnd = {1'b0, stg_q[6].ln[l].scaled} + ROUND_HALF;
      r   = rnd[47:31];
      stg_d[7].ln[l].disp = stg_q[6].ln[l].neg ? -{1'b0, r} : {1'b0, r};
    end

    // position update with saturation
    stg_d[8] = stg_q[7];
    pos_sum = {stg_q[7].pos_x[31], stg_q[7].pos_x}
            + {{15{stg_q[7].ln[0].disp[17]}}, stg_q[7].ln[0].disp};
    if (pos_sum[32] != pos_sum[31]) begin
      stg_d[8].pos_x = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      stg_d[8].sat   = 1'b1;
    end else begin
      stg_d[8].pos_x = pos_sum[31:0];
    end
    pos_sum = {stg_q[7].pos_y[31], stg_q[7].pos_y}
            + {{15{stg_q[7].ln[1].disp[17]}}, stg_q[7].ln[1].disp};
    if (pos_sum[32] != pos_sum[31]) begin
      stg_d[8].pos_y = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      stg_d[8].sat   = 1'b1;
    end else begin
      stg_d[8].pos_y = pos_sum[31:0];
    end
  end

  assign out_o.valid       = vld_q[NUM_STG-1];
  assign out_o.est_x       = stg_q[NUM_STG-1].pos_x;
  assign out_o.est_y       = stg_q[NUM_STG-1].pos_y;
  assign out_o.est_heading = stg_q[NUM_STG-1].heading;
  assign out_o.est_speed   = stg_q[NUM_STG-1].speed;
  assign out_o.saturated   = stg_q[NUM_STG-1].sat;

`ifndef SYNTHESIS
  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted word missing from first stage");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> in_i.ready)
    else $error("input stalled with an empty first stage");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (stg_q[4].ln[0].trig <= QUARTER_TURN[14:0])
              && (stg_q[4].ln[1].trig <= QUARTER_TURN[14:0]))
    else $error("trig magnitude above one");

  a_speed_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && stg_q[0].sat |-> (stg_q[0].speed == 16'sh7FFF)
                              || (stg_q[0].speed == 16'sh8000))
    else $error("speed flag without clipped speed");
`endif

endmodule
